// ===== hw/rtl/fs_pkg.sv =====
package fs_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;

	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int REQ_W   = 2;
	localparam int VALUE_W = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [DATA_WIDTH-1:0] data_t;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH = 2'd0,
		REQ_POP  = 2'd1,
		REQ_FLIP = 2'd2,
		REQ_PEEK = 2'd3
	} req_type_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// slot access issued in the accept cycle
	typedef struct packed {
		logic  we;
		logic  re;
		idx_t  addr;
		data_t wdata;
	} mem_cmd_t;

	// result fields known at accept time
	typedef struct packed {
		logic    is_read;
		status_t status;
		logic    empty;
		cnt_t    count;
	} res_t;

	// base + off around the ring; off < DEPTH, so one conditional subtract
	function automatic idx_t ring_add(input idx_t base, input cnt_t off);
		logic [IDX_W:0] s;
		s = (IDX_W+1)'(base) + (IDX_W+1)'(off);
		if (s >= (IDX_W+1)'(DEPTH)) begin
			s = s - (IDX_W+1)'(DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

	function automatic idx_t ring_next(input idx_t i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic idx_t ring_prev(input idx_t i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
	endfunction

endpackage

// ===== hw/rtl/fs_req_if.sv =====
interface fs_req_if import fs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [REQ_W-1:0]   req_type;
	logic [VALUE_W-1:0] push_value;

	modport source(output valid, req_type, push_value, input ready);
	modport sink(input valid, req_type, push_value, output ready);
endinterface

// ===== hw/rtl/fs_rsp_if.sv =====
interface fs_rsp_if import fs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] read_value;
	logic [STAT_W-1:0]  status;
	logic               is_empty;
	logic [COUNT_W-1:0] item_count;

	modport source(output valid, read_value, status, is_empty, item_count, input ready);
	modport sink(input valid, read_value, status, is_empty, item_count, output ready);
endinterface

// ===== hw/rtl/fs_slot_ram.sv =====
module fs_slot_ram #(
	parameter int DEPTH_P = 16,
	parameter int WIDTH_P = 32
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic                       re,
	input  logic [$clog2(DEPTH_P)-1:0] addr,
	input  logic [WIDTH_P-1:0]         wdata,
	output logic [WIDTH_P-1:0]         rdata
);

	logic [WIDTH_P-1:0] mem_q [DEPTH_P];
	logic [WIDTH_P-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/fs_ctrl.sv =====
module fs_ctrl import fs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [REQ_W-1:0]    req_type,
	input  logic [VALUE_W-1:0]  push_value,
	output mem_cmd_t            cmd,
	output res_t                res
);

	idx_t bottom_q, bottom_d;
	cnt_t count_q, count_d;
	logic rev_q, rev_d;

	always_comb begin
		bottom_d    = bottom_q;
		count_d     = count_q;
		rev_d       = rev_q;
		cmd.we      = 1'b0;
		cmd.re      = 1'b0;
		cmd.addr    = bottom_q;
		cmd.wdata   = DATA_WIDTH'(push_value);
		res.is_read = 1'b0;
		res.status  = ST_OK;
		case (req_type_t'(req_type))
			REQ_PUSH: begin
				if (count_q == CNT_W'(DEPTH)) begin
					res.status = ST_FULL;
				end else begin
					cmd.we  = 1'b1;
					count_d = count_q + 1'b1;
					if (rev_q) begin
						// reversed: grow downward from the low end
						bottom_d = ring_prev(bottom_q);
						cmd.addr = bottom_d;
					end else begin
						cmd.addr = ring_add(bottom_q, count_q);
					end
				end
			end
			REQ_POP, REQ_PEEK: begin
				if (count_q == '0) begin
					res.status = ST_EMPTY;
				end else begin
					cmd.re      = 1'b1;
					res.is_read = 1'b1;
					cmd.addr    = rev_q ? bottom_q : ring_add(bottom_q, count_q - 1'b1);
					if (req_type_t'(req_type) == REQ_POP) begin
						count_d = count_q - 1'b1;
						if (rev_q) begin
							bottom_d = ring_next(bottom_q);
						end
					end
				end
			end
			REQ_FLIP: begin
				rev_d = ~rev_q;
			end
			default: begin
				res.status = ST_OK;
			end
		endcase
		res.count = count_d;
		res.empty = (count_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bottom_q <= '0;
			count_q  <= '0;
			rev_q    <= 1'b0;
		end else if (fire) begin
			bottom_q <= bottom_d;
			count_q  <= count_d;
			rev_q    <= rev_d;
		end
	end

endmodule

// ===== hw/rtl/flippable_stack.sv =====
// A result beat is valid in the cycle after its request is accepted.
// Throughput: one request per cycle when not stalled; slot writes and reads use the
// single port of the slot RAM in the accept cycle, read data registered by the RAM.
// While a result beat is stalled no request is taken; ready returns with rsp.ready.
// Reset (arst_n low): stack empty, normal order, no result pending.
module flippable_stack import fs_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	fs_req_if.sink   req,
	fs_rsp_if.source rsp
);

	logic     fire;
	logic     rsp_valid_q;
	mem_cmd_t cmd;
	res_t     res;
	res_t     res_s1;
	data_t    rdata;

	assign req.ready = ~rsp_valid_q | rsp.ready;
	assign fire      = req.valid & req.ready;

	fs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.req_type   (req.req_type),
		.push_value (req.push_value),
		.cmd        (cmd),
		.res        (res)
	);

	fs_slot_ram #(
		.DEPTH_P (DEPTH),
		.WIDTH_P (DATA_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.we & fire),
		.re    (cmd.re & fire),
		.addr  (cmd.addr),
		.wdata (cmd.wdata),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req.ready) begin
			rsp_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s1 <= res;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = res_s1.is_read ? VALUE_W'(rdata) : '0;
	assign rsp.status     = res_s1.status;
	assign rsp.is_empty   = res_s1.empty;
	assign rsp.item_count = COUNT_W'(res_s1.count);

endmodule

// ===== test/tb_flippable_stack.sv =====
module tb_flippable_stack;
	import fs_pkg::*;

	localparam int RANDOM_ITEMS = 1100;
	localparam int CALM_TAIL    = 150;
	localparam int HOLD_AFTER   = 200;
	localparam int HOLD_CYCLES  = 120;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_PRINTS   = 60;

	typedef struct {
		req_type_t          op;
		logic [VALUE_W-1:0] value;
	} stack_req_t;

	typedef struct {
		logic [VALUE_W-1:0] read_value;
		status_t            status;
		logic               is_empty;
		logic [COUNT_W-1:0] item_count;
	} stack_reply_t;

	logic clk;
	logic arst_n;

	fs_req_if req_bus();
	fs_rsp_if rsp_bus();

	flippable_stack u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	stack_req_t   pending_reqs[$];
	stack_reply_t stack_replies_due[$];

	// predicted stack contents: ring of slots, low end at ring_base
	data_t ring_slots[DEPTH];
	int    ring_base;
	int    held;
	bit    flipped;

	int total_reqs;
	int beats_taken;
	int results_seen;
	int error_count;
	int cycle_count;
	int send_gap;
	int stall_left;
	int hold_left;
	bit hold_done;
	bit calm;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function stack_reply_t stack_model_step(req_type_t op, logic [VALUE_W-1:0] value);
		stack_reply_t r;
		int top;
		r.read_value = '0;
		r.status     = ST_OK;
		case (op)
			REQ_PUSH: begin
				if (held == DEPTH) begin
					r.status = ST_FULL;
				end else if (flipped) begin
					ring_base = (ring_base + DEPTH - 1) % DEPTH;
					ring_slots[ring_base] = value[DATA_WIDTH-1:0];
					held++;
				end else begin
					ring_slots[(ring_base + held) % DEPTH] = value[DATA_WIDTH-1:0];
					held++;
				end
			end
			REQ_POP, REQ_PEEK: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					// top sits at the low end once flipped
					top = flipped ? ring_base : (ring_base + held - 1) % DEPTH;
					r.read_value = VALUE_W'(ring_slots[top]);
					if (op == REQ_POP) begin
						if (flipped) begin
							ring_base = (ring_base + 1) % DEPTH;
						end
						held--;
					end
				end
			end
			default: begin
				flipped = !flipped;
			end
		endcase
		r.is_empty   = (held == 0);
		r.item_count = COUNT_W'(held);
		return r;
	endfunction

	task automatic flag_mismatch(string msg);
		error_count++;
		if (error_count <= MAX_PRINTS) begin
			$display("MISMATCH cycle %0d: %s", cycle_count, msg);
		end
	endtask

	task automatic add_req(req_type_t op, logic [VALUE_W-1:0] value);
		stack_req_t item;
		item.op    = op;
		item.value = value;
		pending_reqs.push_back(item);
		total_reqs++;
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] v;
		v = $urandom;
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: v = '0;
				1: v = '1;
				2: v = 32'h8000_0000;
				default: v = 32'h7fff_ffff;
			endcase
		end
		return v;
	endfunction

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
		end else begin
			if (req_bus.valid && req_bus.ready) begin
				stack_replies_due.push_back(
					stack_model_step(req_type_t'(req_bus.req_type), req_bus.push_value));
				beats_taken++;
			end
			calm = (pending_reqs.size() < CALM_TAIL);
			if (!req_bus.valid || req_bus.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_bus.valid <= 1'b0;
				end else if (!calm && pending_reqs.size() > 0 && $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(1, 18) - 1;
					req_bus.valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					req_bus.valid      <= 1'b1;
					req_bus.req_type   <= pending_reqs[0].op;
					req_bus.push_value <= pending_reqs[0].value;
					void'(pending_reqs.pop_front());
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	// result ready: random stalls plus one long hold so the stack backs up
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rsp_bus.ready <= 1'b0;
		end else if (!hold_done && results_seen >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			rsp_bus.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_bus.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 6) == 0) begin
			stall_left = $urandom_range(1, 18) - 1;
			rsp_bus.ready <= 1'b0;
		end else begin
			rsp_bus.ready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin : check_replies
		stack_reply_t due;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			results_seen++;
			if (stack_replies_due.size() == 0) begin
				flag_mismatch("result beat with no request outstanding");
			end else begin
				due = stack_replies_due.pop_front();
				if (rsp_bus.read_value !== due.read_value)
					flag_mismatch($sformatf("beat %0d read_value %h, expected %h",
						results_seen, rsp_bus.read_value, due.read_value));
				if (rsp_bus.status !== due.status)
					flag_mismatch($sformatf("beat %0d status %0d, expected %0d",
						results_seen, rsp_bus.status, due.status));
				if (rsp_bus.is_empty !== due.is_empty)
					flag_mismatch($sformatf("beat %0d is_empty %b, expected %b",
						results_seen, rsp_bus.is_empty, due.is_empty));
				if (rsp_bus.item_count !== due.item_count)
					flag_mismatch($sformatf("beat %0d item_count %0d, expected %0d",
						results_seen, rsp_bus.item_count, due.item_count));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still due",
				cycle_count, stack_replies_due.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin : stimulus
		int made;
		int seg_len;
		int seg_kind;
		int r;
		clk                = 1'b0;
		arst_n             = 1'b0;
		req_bus.valid      = 1'b0;
		req_bus.req_type   = REQ_PUSH;
		req_bus.push_value = '0;
		rsp_bus.ready      = 1'b0;
		ring_base          = 0;
		held               = 0;
		flipped            = 1'b0;

		// empty stack corners, flips around small sizes, field extremes
		add_req(REQ_POP,  32'hdead_beef);
		add_req(REQ_PEEK, 32'h0);
		add_req(REQ_FLIP, 32'h0);
		add_req(REQ_FLIP, 32'hffff_ffff);
		add_req(REQ_PUSH, 32'h0);
		add_req(REQ_FLIP, 32'h0);
		add_req(REQ_PEEK, 32'h0);
		add_req(REQ_FLIP, 32'h0);
		add_req(REQ_PUSH, 32'hffff_ffff);
		add_req(REQ_PUSH, 32'h8000_0000);
		add_req(REQ_PEEK, 32'h0);
		add_req(REQ_FLIP, 32'h0);
		add_req(REQ_PEEK, 32'h0);
		add_req(REQ_PUSH, 32'h7fff_ffff);  // lands below the low end
		add_req(REQ_POP,  32'h0);
		add_req(REQ_POP,  32'h0);
		add_req(REQ_FLIP, 32'h0);
		add_req(REQ_POP,  32'h0);
		add_req(REQ_POP,  32'h0);
		add_req(REQ_POP,  32'h0);
		add_req(REQ_PEEK, 32'h0);

		// segments biased toward filling, draining or mixing
		made = 0;
		while (made < RANDOM_ITEMS) begin
			seg_len  = $urandom_range(8, 40);
			seg_kind = $urandom_range(0, 2);
			for (int i = 0; i < seg_len; i++) begin
				r = $urandom_range(0, 19);
				case (seg_kind)
					0: begin
						if (r < 16 || r == 19) add_req(REQ_PUSH, pick_value());
						else if (r == 16) add_req(REQ_FLIP, pick_value());
						else if (r == 17) add_req(REQ_PEEK, pick_value());
						else add_req(REQ_POP, pick_value());
					end
					1: begin
						if (r < 14) add_req(REQ_POP, pick_value());
						else if (r < 16) add_req(REQ_FLIP, pick_value());
						else if (r < 18) add_req(REQ_PEEK, pick_value());
						else add_req(REQ_PUSH, pick_value());
					end
					default: begin
						if (r < 8) add_req(REQ_PUSH, pick_value());
						else if (r < 14) add_req(REQ_POP, pick_value());
						else if (r < 17) add_req(REQ_PEEK, pick_value());
						else add_req(REQ_FLIP, pick_value());
					end
				endcase
				made++;
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (beats_taken < total_reqs) @(posedge clk);
		while (stack_replies_due.size() != 0) @(posedge clk);
		// keep running a little longer to catch stray result beats
		repeat (5) @(posedge clk);

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
